// ===== rtl/id3v2_cover_image_extractor_core_defines.svh =====
// Assertion macros shared by the ID3v2 cover image extractor RTL.
// Each macro expects clk_i and rst_ni to exist in the using module.
`ifndef ID3V2_COVER_IMAGE_EXTRACTOR_CORE_DEFINES_SVH
`define ID3V2_COVER_IMAGE_EXTRACTOR_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define ID3CE_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ID3CE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/id3ce_pkg.sv =====
// Package for the ID3v2 cover image extractor: parse phases, status codes,
// result item type and header constants. No dependencies.
package id3ce_pkg;

  typedef enum logic [3:0] {
    PH_TAG   = 4'd0,
    PH_FHDR  = 4'd1,
    PH_SKIP  = 4'd2,
    PH_ENC   = 4'd3,
    PH_MIME  = 4'd4,
    PH_PTYPE = 4'd5,
    PH_DESC  = 4'd6,
    PH_IMG0  = 4'd7,
    PH_IMG   = 4'd8,
    PH_DONE  = 4'd9
  } phase_e;

  typedef enum logic [1:0] {
    ST_IMAGE    = 2'd0,
    ST_NOT_ID3  = 2'd1,
    ST_NO_COVER = 2'd2,
    ST_TRUNC    = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] image_byte;
    logic       done_res;
    status_e    status;
  } res_t;

  localparam logic [3:0]  HdrLast     = 4'd9;   // index of the last header byte
  localparam logic [3:0]  MagicBytes  = 4'd3;
  localparam logic [3:0]  VersionIdx  = 4'd3;
  localparam logic [3:0]  SizeFirst   = 4'd6;
  localparam logic [3:0]  IdentBytes  = 4'd4;
  localparam logic [3:0]  LenEnd      = 4'd8;
  localparam logic [7:0]  SyncVersion = 8'd4;
  localparam logic [31:0] ApicId      = 32'h4150_4943;
  localparam logic [29:0] HdrBytes    = 30'd10;
  localparam int unsigned PosW        = 30;     // tag position plus one header

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = 8'h49;
      2'd1:    r = 8'h44;
      default: r = 8'h33;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/id3ce_if.sv =====
// Valid/ready channel interfaces for the ID3v2 cover image extractor.
// Depends on id3ce_pkg for the status type.
interface id3ce_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;

  modport source (output valid, output data_byte, output end_of_file, input ready);
  modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface id3ce_out_if
  import id3ce_pkg::*;
;
  logic       valid;
  logic       ready;
  logic [7:0] image_byte;
  logic       done_res;
  status_e    status;

  modport source (output valid, output image_byte, output done_res, output status,
                  input ready);
  modport sink   (input valid, input image_byte, input done_res, input status,
                  output ready);
endinterface

// ===== rtl/id3ce_parser.sv =====
// Byte-level ID3v2 tag/frame walker: one file byte per accepted item,
// at most one result item per byte. Depends on id3ce_pkg and the defines header.
`include "id3v2_cover_image_extractor_core_defines.svh"

module id3ce_parser
  import id3ce_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_file_i,
  output logic       res_valid_o,
  output res_t       res_o
);

  phase_e            phase_q, phase_d;
  logic [3:0]        hcnt_q, hcnt_d;      // tag header byte count
  logic              ver4_q, ver4_d;      // syncsafe frame sizes
  logic [27:0]       tlen_q, tlen_d;
  logic [PosW-1:0]   rel_q, rel_d;        // tag position + 10
  logic [3:0]        fcnt_q, fcnt_d;      // frame header byte count
  logic [31:0]       fid_q, fid_d;
  logic [31:0]       flen_q, flen_d;
  logic [27:0]       rem_q, rem_d;        // bytes left in current frame

  logic [27:0]       tlen_shift;
  logic [PosW-1:0]   rel_sum;
  logic              last_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TAG;
      hcnt_q  <= '0;
      ver4_q  <= 1'b0;
      tlen_q  <= '0;
      rel_q   <= '0;
      fcnt_q  <= '0;
      fid_q   <= '0;
      flen_q  <= '0;
      rem_q   <= '0;
    end else begin
      phase_q <= phase_d;
      hcnt_q  <= hcnt_d;
      ver4_q  <= ver4_d;
      tlen_q  <= tlen_d;
      rel_q   <= rel_d;
      fcnt_q  <= fcnt_d;
      fid_q   <= fid_d;
      flen_q  <= flen_d;
      rem_q   <= rem_d;
    end
  end

  assign tlen_shift = {tlen_q[20:0], data_byte_i[6:0]};
  assign rel_sum    = rel_q + PosW'(flen_q[27:0]);
  assign last_byte  = (rem_q == 28'd1);

  always_comb begin
    phase_d     = phase_q;
    hcnt_d      = hcnt_q;
    ver4_d      = ver4_q;
    tlen_d      = tlen_q;
    rel_d       = rel_q;
    fcnt_d      = fcnt_q;
    fid_d       = fid_q;
    flen_d      = flen_q;
    rem_d       = rem_q;
    res_valid_o = 1'b0;
    res_o       = '{image_byte: 8'd0, done_res: 1'b0, status: ST_IMAGE};

    if (accept_i) begin
      if (end_of_file_i) begin
        case (phase_q)
          PH_TAG: begin
            res_valid_o = 1'b1;
            res_o       = '{image_byte: 8'd0, done_res: 1'b1, status: ST_NOT_ID3};
          end
          PH_IMG: begin
            res_valid_o = 1'b1;
            res_o       = '{image_byte: 8'd0, done_res: 1'b1, status: ST_TRUNC};
          end
          PH_DONE: ;
          default: begin
            res_valid_o = 1'b1;
            res_o       = '{image_byte: 8'd0, done_res: 1'b1, status: ST_NO_COVER};
          end
        endcase
        phase_d = PH_TAG;
        hcnt_d  = '0;
        ver4_d  = 1'b0;
        tlen_d  = '0;
        rel_d   = '0;
        fcnt_d  = '0;
        fid_d   = '0;
        flen_d  = '0;
        rem_d   = '0;
      end else begin
        case (phase_q)
          PH_TAG: begin
            if (hcnt_q < MagicBytes && data_byte_i != magic_byte(hcnt_q[1:0])) begin
              res_valid_o = 1'b1;
              res_o       = '{image_byte: 8'd0, done_res: 1'b1, status: ST_NOT_ID3};
              phase_d     = PH_DONE;
            end else begin
              if (hcnt_q == VersionIdx) ver4_d = (data_byte_i >= SyncVersion);
              if (hcnt_q >= SizeFirst) tlen_d = tlen_shift;
              hcnt_d = hcnt_q + 4'd1;
              if (hcnt_q == HdrLast) begin
                rel_d = HdrBytes;
                if (HdrBytes < {2'b00, tlen_shift}) begin
                  phase_d = PH_FHDR;
                  fcnt_d  = '0;
                  fid_d   = '0;
                  flen_d  = '0;
                end else begin
                  res_valid_o = 1'b1;
                  res_o = '{image_byte: 8'd0, done_res: 1'b1, status: ST_NO_COVER};
                  phase_d = PH_DONE;
                end
              end
            end
          end
          PH_FHDR: begin
            if (fcnt_q < IdentBytes) begin
              fid_d = {fid_q[23:0], data_byte_i};
            end else if (fcnt_q < LenEnd) begin
              flen_d = ver4_q ? {flen_q[24:0], data_byte_i[6:0]}
                              : {flen_q[23:0], data_byte_i};
            end
            fcnt_d = fcnt_q + 4'd1;
            if (fcnt_q == HdrLast) begin
              rel_d = rel_q + HdrBytes;
              if (flen_q == 32'd0 || flen_q > {4'd0, tlen_q}) begin
                res_valid_o = 1'b1;
                res_o = '{image_byte: 8'd0, done_res: 1'b1, status: ST_NO_COVER};
                phase_d = PH_DONE;
              end else begin
                rem_d   = flen_q[27:0];
                phase_d = (fid_q == ApicId) ? PH_ENC : PH_SKIP;
              end
            end
          end
          PH_SKIP: begin
            rem_d = rem_q - 28'd1;
            if (last_byte) begin
              rel_d = rel_sum;
              if (rel_sum < {2'b00, tlen_q}) begin
                phase_d = PH_FHDR;
                fcnt_d  = '0;
                fid_d   = '0;
                flen_d  = '0;
              end else begin
                res_valid_o = 1'b1;
                res_o = '{image_byte: 8'd0, done_res: 1'b1, status: ST_NO_COVER};
                phase_d = PH_DONE;
              end
            end
          end
          PH_ENC, PH_MIME, PH_PTYPE, PH_DESC: begin
            if (last_byte) begin
              res_valid_o = 1'b1;
              res_o = '{image_byte: 8'd0, done_res: 1'b1, status: ST_NO_COVER};
              phase_d = PH_DONE;
            end else begin
              rem_d = rem_q - 28'd1;
              case (phase_q)
                PH_ENC:   phase_d = PH_MIME;
                PH_MIME:  phase_d = (data_byte_i == 8'd0) ? PH_PTYPE : PH_MIME;
                PH_PTYPE: phase_d = PH_DESC;
                default:  phase_d = (data_byte_i == 8'd0) ? PH_IMG0 : PH_DESC;
              endcase
            end
          end
          PH_IMG0, PH_IMG: begin
            res_valid_o = 1'b1;
            if (last_byte) begin
              res_o   = '{image_byte: data_byte_i, done_res: 1'b1, status: ST_IMAGE};
              phase_d = PH_DONE;
            end else begin
              res_o   = '{image_byte: data_byte_i, done_res: 1'b0, status: ST_IMAGE};
              phase_d = PH_IMG;
              rem_d   = rem_q - 28'd1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // once a final result went out, data bytes are swallowed silently
  `ID3CE_ASSERT_NOW(a_done_quiet, accept_i && !end_of_file_i && phase_q == PH_DONE, !res_valid_o, "result after final item")
  // a final result always parks the walker or restarts it
  `ID3CE_ASSERT_NEXT(a_final_parks, res_valid_o && res_o.done_res, phase_q == PH_DONE || phase_q == PH_TAG, "walker kept running after final item")
  // image phase is only entered by emitting a byte
  `ID3CE_ASSERT_NEXT(a_img_entry, accept_i && !end_of_file_i && phase_q == PH_IMG0 && !res_valid_o, 1'b0, "image byte dropped")

endmodule

// ===== rtl/id3ce_out_buf.sv =====
// Two-entry result buffer between the walker and the output channel; lets
// the input side keep taking items while a result waits. Depends on id3ce_pkg.
`include "id3v2_cover_image_extractor_core_defines.svh"

module id3ce_out_buf
  import id3ce_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t push_data_i,
  output logic space_o,
  output logic valid_o,
  input  logic pop_i,
  output res_t pop_data_o
);

  res_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign pop        = pop_i && valid_o;
  assign valid_o    = (cnt_q != 2'd0);
  assign space_o    = (cnt_q != 2'd2);
  assign pop_data_o = slot_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    case ({push_i, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop)    rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= push_data_i;
  end

  `ID3CE_ASSERT_NOW(a_no_overflow, cnt_q == 2'd2, !push_i, "push into full result buffer")
  `ID3CE_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q != 2'd3, "result count out of range")
  `ID3CE_ASSERT_NEXT(a_ptr_track, 1'b1, (cnt_q == 2'd1) == (wr_ptr_q != rd_ptr_q), "pointers disagree with count")

endmodule

// ===== rtl/id3v2_cover_image_extractor_core.sv =====
// Top level of the ID3v2 cover image extractor: tag/frame walker plus
// result buffer. Depends on id3ce_pkg, id3ce_if, id3ce_parser, id3ce_out_buf.
//
//   channel  dir  payload                           item
//   in_i     in   data_byte[8], end_of_file[1]      one file byte or end of file
//   out_o    out  image_byte[8], done_res, status   picture byte or final status
//
// One input item per cycle while in_i.ready is high; its result (if any) is written
// to the buffer at the same edge and can leave in the next cycle.
// Throughput is set by the walker's single state update per byte.
// Reset (rst_ni low, async) returns the walker to the tag header and empties
// the buffer. in_i.ready drops only while both buffer slots hold results.

module id3v2_cover_image_extractor_core
  import id3ce_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  id3ce_in_if.sink     in_i,
  id3ce_out_if.source  out_o
);

  logic accept;
  logic space;
  logic res_valid;
  res_t res;
  res_t head;

  assign in_i.ready = space;
  assign accept     = in_i.valid && space;

  id3ce_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (in_i.data_byte),
    .end_of_file_i (in_i.end_of_file),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  id3ce_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .space_o     (space),
    .valid_o     (out_o.valid),
    .pop_i       (out_o.ready),
    .pop_data_o  (head)
  );

  assign out_o.image_byte = head.image_byte;
  assign out_o.done_res   = head.done_res;
  assign out_o.status     = head.status;

endmodule

// ===== tb/sv/tb_id3v2_cover_image_extractor_core.sv =====
// Testbench for id3v2_cover_image_extractor_core: streams ID3v2 files byte by byte
// and checks every picture byte and final status against a built-in tag walker.
// Depends on id3ce_pkg, id3ce_if and the core RTL.
module tb_id3v2_cover_image_extractor_core;
  import id3ce_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HEADER_LEN    = 10;
  localparam int unsigned MAGIC_LEN     = 3;
  localparam logic [23:0] ID3_MAGIC     = "ID3";
  localparam logic [31:0] PICTURE_ID    = "APIC";
  localparam logic [7:0]  SYNCSAFE_VER  = 8'd4;
  localparam int unsigned RANDOM_ITEMS  = 1150;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned DRAIN_CYCLES  = 20;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned MAX_REPORTS   = 40;

  logic clk_i = 1'b0;
  logic rst_ni;

  id3ce_in_if  in_if ();
  id3ce_out_if out_if ();

  id3v2_cover_image_extractor_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Tag walker state
  phase_e      walk_phase;
  logic [3:0]  hdr_seen;
  logic [7:0]  tag_ver;
  logic [27:0] tag_len;
  logic [32:0] tag_pos;
  logic [3:0]  fhdr_seen;
  logic [31:0] frame_id;
  logic [31:0] frame_len;
  logic [31:0] frame_off;

  res_t        pending_results[$];
  logic [7:0]  file_q[$];
  logic [7:0]  body_q[$];
  logic [7:0]  frame_q[$];

  int          err_count   = 0;
  int          sent_items  = 0;
  int          burst_left  = 0;
  int          gap_left    = 0;
  int          rx_hold_req = 0;
  int          pic_frames  = 0;

  function automatic void walker_reset();
    walk_phase = PH_TAG;
    hdr_seen   = '0;
    tag_ver    = '0;
    tag_len    = '0;
    tag_pos    = '0;
    fhdr_seen  = '0;
    frame_id   = '0;
    frame_len  = '0;
    frame_off  = '0;
  endfunction

  // Returns 1 when no further frame header fits in the tag; else arms the next header.
  function automatic bit tag_exhausted();
    if ({31'd0, tag_pos} + 64'd10 < {36'd0, tag_len}) begin
      walk_phase = PH_FHDR;
      fhdr_seen  = '0;
      frame_id   = '0;
      frame_len  = '0;
      frame_off  = '0;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit walk_byte(input logic [7:0] b, input logic eof, output res_t r);
    bit     emit;
    bit     last_byte;
    phase_e nxt;
    emit       = 1'b0;
    r          = '0;
    r.done_res = 1'b1;
    if (eof) begin
      emit = (walk_phase != PH_DONE);
      if (walk_phase == PH_TAG) r.status = ST_NOT_ID3;
      else if (walk_phase == PH_IMG) r.status = ST_TRUNC;
      else r.status = ST_NO_COVER;
      walker_reset();
      return emit;
    end
    case (walk_phase)
      PH_TAG: begin
        if (hdr_seen < MAGIC_LEN && b != ID3_MAGIC[8*(2-int'(hdr_seen)) +: 8]) begin
          emit     = 1'b1;
          r.status = ST_NOT_ID3;
        end else begin
          if (hdr_seen == 4'd3) tag_ver = b;
          if (hdr_seen >= 4'd6) tag_len = {tag_len[20:0], b[6:0]};
          hdr_seen++;
          if (hdr_seen >= HEADER_LEN) begin
            tag_pos = '0;
            if (tag_exhausted()) begin
              emit     = 1'b1;
              r.status = ST_NO_COVER;
            end
          end
        end
      end
      PH_FHDR: begin
        if (fhdr_seen < 4'd4) frame_id = {frame_id[23:0], b};
        else if (fhdr_seen < 4'd8) begin
          if (tag_ver >= SYNCSAFE_VER) frame_len = {frame_len[24:0], b[6:0]};
          else frame_len = {frame_len[23:0], b};
        end
        fhdr_seen++;
        if (fhdr_seen >= HEADER_LEN) begin
          tag_pos = tag_pos + 33'd10;
          if (frame_len == '0 || frame_len > {4'd0, tag_len}) begin
            emit     = 1'b1;
            r.status = ST_NO_COVER;
          end else begin
            frame_off  = '0;
            walk_phase = (frame_id == PICTURE_ID) ? PH_ENC : PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        frame_off++;
        if (frame_off >= frame_len) begin
          tag_pos = tag_pos + {1'b0, frame_len};
          if (tag_exhausted()) begin
            emit     = 1'b1;
            r.status = ST_NO_COVER;
          end
        end
      end
      PH_ENC, PH_MIME, PH_PTYPE, PH_DESC, PH_IMG0, PH_IMG: begin
        last_byte = (frame_off + 32'd1 >= frame_len);
        if (walk_phase == PH_IMG0 || walk_phase == PH_IMG) begin
          emit         = 1'b1;
          r.image_byte = b;
          r.status     = ST_IMAGE;
          r.done_res   = last_byte;
          if (!last_byte) begin
            walk_phase = PH_IMG;
            frame_off++;
          end
        end else begin
          nxt = walk_phase;
          case (walk_phase)
            PH_ENC:   nxt = PH_MIME;
            PH_MIME:  if (b == 8'h00) nxt = PH_PTYPE;
            PH_PTYPE: nxt = PH_DESC;
            PH_DESC:  if (b == 8'h00) nxt = PH_IMG0;
            default:  nxt = walk_phase;
          endcase
          if (last_byte) begin
            emit     = 1'b1;
            r.status = ST_NO_COVER;
          end else begin
            frame_off++;
            walk_phase = nxt;
          end
        end
      end
      default: emit = 1'b0;
    endcase
    if (emit && r.done_res) walk_phase = PH_DONE;
    return emit;
  endfunction

  // ---------------------------------------------------------------------------
  // File generation
  function automatic logic [31:0] syncsafe_word(input logic [27:0] v, input bit noisy);
    logic [31:0] w;
    w = {1'b0, v[27:21], 1'b0, v[20:14], 1'b0, v[13:7], 1'b0, v[6:0]};
    if (noisy) w = w | ($urandom & 32'h8080_8080);
    return w;
  endfunction

  // Random non-null string, usually null-terminated
  function automatic void add_text(input bit unterminated);
    repeat ($urandom_range(0, 6)) frame_q.push_back(8'($urandom_range(1, 255)));
    if (!unterminated) frame_q.push_back(8'h00);
  endfunction

  function automatic void build_file(input int unsigned img_lo, input int unsigned img_hi,
                                     input bit clean);
    logic [7:0]  ver;
    logic [31:0] ident;
    logic [31:0] size_w;
    int unsigned kind;
    int unsigned fsize;
    int unsigned tlen;
    int unsigned cut;
    body_q.delete();
    file_q.delete();
    pic_frames = 0;
    case ($urandom_range(0, 5))
      0:       ver = 8'd2;
      1:       ver = 8'd3;
      5:       ver = clean ? 8'd4 : 8'($urandom_range(0, 255));
      default: ver = 8'd4;
    endcase
    repeat ($urandom_range(1, 4)) begin
      // 0..4 picture frame, 5..7 other frame, 8 bad size, 9 near-miss ident
      kind = clean ? $urandom_range(3, 7) : $urandom_range(0, 9);
      frame_q.delete();
      ident = $urandom;
      if (kind <= 4) begin
        ident = PICTURE_ID;
        pic_frames++;
        frame_q.push_back(8'($urandom_range(0, 255)));
        add_text(!clean && $urandom_range(0, 9) == 0);
        frame_q.push_back(8'($urandom_range(0, 255)));
        add_text(!clean && $urandom_range(0, 9) == 0);
        repeat ($urandom_range(img_lo, img_hi))
          frame_q.push_back(8'($urandom_range(0, 255)));
        fsize = frame_q.size();
        if (!clean && $urandom_range(0, 7) == 0) fsize = $urandom_range(1, fsize);
      end else begin
        if (kind == 9) ident = PICTURE_ID ^ (32'd1 << $urandom_range(0, 31));
        repeat ($urandom_range(1, 10)) frame_q.push_back(8'($urandom_range(0, 255)));
        fsize = frame_q.size();
      end
      if (kind == 8) begin
        if ($urandom_range(0, 1) == 0)
          size_w = (ver >= SYNCSAFE_VER) ? ($urandom & 32'h8080_8080) : 32'd0;
        else
          size_w = (ver >= SYNCSAFE_VER) ? 32'h7F7F_7F7F : (32'hF000_0000 | $urandom);
      end else if (ver >= SYNCSAFE_VER) begin
        size_w = syncsafe_word(28'(fsize), !clean);
      end else begin
        size_w = fsize;
      end
      for (int i = 3; i >= 0; i--) body_q.push_back(ident[8*i +: 8]);
      for (int i = 3; i >= 0; i--) body_q.push_back(size_w[8*i +: 8]);
      repeat (2) body_q.push_back(8'($urandom_range(0, 255)));
      foreach (frame_q[i]) body_q.push_back(frame_q[i]);
    end
    case (clean ? 0 : $urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: tlen = body_q.size() + $urandom_range(0, 16);
      6, 7, 8:          tlen = $urandom_range(0, body_q.size() + 20);
      default:          tlen = $urandom_range(28'h100_0000, 28'hFFF_FFFF);
    endcase
    for (int i = 2; i >= 0; i--) file_q.push_back(ID3_MAGIC[8*i +: 8]);
    file_q.push_back(ver);
    repeat (2) file_q.push_back(8'($urandom_range(0, 255)));
    size_w = syncsafe_word(28'(tlen), !clean && $urandom_range(0, 3) == 0);
    for (int i = 3; i >= 0; i--) file_q.push_back(size_w[8*i +: 8]);
    foreach (body_q[i]) file_q.push_back(body_q[i]);
    cut = (tlen > body_q.size()) ? tlen - body_q.size() : 0;
    if (cut > 16) cut = 16;
    repeat (cut) file_q.push_back(8'h00);
    repeat ($urandom_range(0, 4)) file_q.push_back(8'($urandom_range(0, 255)));
    if (!clean) begin
      if ($urandom_range(0, 15) == 0)
        file_q[$urandom_range(0, 2)] ^= 8'(1 << $urandom_range(0, 7));
      if ($urandom_range(0, 5) == 0) begin
        cut = $urandom_range(0, file_q.size());
        while (file_q.size() > cut) void'(file_q.pop_back());
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  task automatic send_item(input logic [7:0] b, input logic eof);
    res_t   r;
    while (gap_left > 0) begin
      @(posedge clk_i);
      gap_left--;
    end
    in_if.valid       <= 1'b1;
    in_if.data_byte   <= b;
    in_if.end_of_file <= eof;
    do @(posedge clk_i); while (!in_if.ready);
    if (walk_byte(b, eof, r)) pending_results.push_back(r);
    sent_items++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
      gap_left     = $urandom_range(1, 12);
      in_if.valid <= 1'b0;
    end
  endtask

  task automatic send_file();
    foreach (file_q[i]) send_item(file_q[i], 1'b0);
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: stall pattern plus requested long hold-offs
  initial begin : receiver
    int hold_left;
    int mode;
    int mode_left;
    int tick;
    hold_left    = 0;
    mode         = 0;
    mode_left    = 0;
    tick         = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (rx_hold_req > 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0:       out_if.ready <= 1'b1;
          1:       out_if.ready <= ($urandom_range(0, 3) != 0);
          default: out_if.ready <= ((tick % 7) < 4);
        endcase
      end
    end
  end

  task automatic report_field(input string name, input int want, input int got);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
  endtask

  always @(posedge clk_i) begin : check_results
    res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual byte %0h done %0b status %0d",
                   $time, out_if.image_byte, out_if.done_res, out_if.status);
      end else begin
        want = pending_results.pop_front();
        if (out_if.image_byte !== want.image_byte)
          report_field("image_byte", want.image_byte, out_if.image_byte);
        if (out_if.done_res !== want.done_res)
          report_field("done_res", want.done_res, out_if.done_res);
        if (out_if.status !== want.status)
          report_field("status", want.status, out_if.status);
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    wait (rst_ni === 1'b1);
    while (idle < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle = 0;
      else idle++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  task automatic test_header_errors();
    file_q.delete();                            // end of file before any byte
    send_file();
    file_q = '{8'h58, 8'hFF};                   // bad first byte, rest ignored
    send_file();
    file_q = '{8'h49, 8'h44, 8'h00};            // bad third byte
    send_file();
    file_q = '{8'h49, 8'h44, 8'h33, 8'h04, 8'h00, 8'h00};   // short header
    send_file();
    // tag size masks to zero: search ends on the last header byte
    file_q = '{8'h49, 8'h44, 8'h33, 8'h03, 8'h00, 8'h00,
               8'h80, 8'h80, 8'h80, 8'h80, 8'hFF};
    send_file();
  endtask

  task automatic test_random_files();
    sent_items = 0;
    while (sent_items < RANDOM_ITEMS) begin
      build_file(0, 12, $urandom_range(0, 3) == 0);
      send_file();
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
  endtask

  // Long receiver hold-off while a long picture streams in, then a full drain
  task automatic test_backpressure();
    do build_file(60, 90, 1'b1); while (pic_frames == 0);
    rx_hold_req = HOLD_CYCLES;
    send_file();
    wait_drained();
  endtask

  initial begin
    in_if.valid       = 1'b0;
    in_if.data_byte   = 8'h00;
    in_if.end_of_file = 1'b0;
    rst_ni            = 1'b0;
    walker_reset();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_header_errors();
    test_backpressure();
    test_random_files();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
